/* hw/rtl/rrt_pkg.sv */
// shared types and constants for the route table
package rrt_pkg;
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int KEY_W = 38;
    localparam int ROUTE_W = 44;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_RIP    = 2'd3;

    localparam logic [3:0] OC_HIT       = 4'd0;
    localparam logic [3:0] OC_MISS      = 4'd1;
    localparam logic [3:0] OC_ADDED     = 4'd2;
    localparam logic [3:0] OC_REPLACED  = 4'd3;
    localparam logic [3:0] OC_DELETED   = 4'd4;
    localparam logic [3:0] OC_UPDATED   = 4'd5;
    localparam logic [3:0] OC_REROUTED  = 4'd6;
    localparam logic [3:0] OC_UNCHANGED = 4'd7;
    localparam logic [3:0] OC_FULL      = 4'd8;
    localparam logic [3:0] OC_UNKNOWN   = 4'd9;

    // route written to the table
    localparam logic [2:0] RSEL_INSERT  = 3'd0;
    localparam logic [2:0] RSEL_RIP_ADD = 3'd1;
    localparam logic [2:0] RSEL_UPDATE  = 3'd2;
    localparam logic [2:0] RSEL_REROUTE = 3'd3;

    // route reported in the result word
    localparam logic [1:0] SRC_NONE  = 2'd0;
    localparam logic [1:0] SRC_NEW   = 2'd1;
    localparam logic [1:0] SRC_EXACT = 2'd2;
    localparam logic [1:0] SRC_LPM   = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic       load;      // capture input word
        logic       scan_start;
        logic       scan_lpm;  // longest match on lookup address or hop instead of exact/free
        logic       wr_new;    // write key and route to free slot
        logic       wr_route;  // rewrite route of exact slot
        logic       del;       // clear valid of exact slot
        logic [2:0] route_sel;
        logic       res_load;
        logic [3:0] res_oc;
        logic [1:0] res_src;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       scan_done;
        logic       exact_hit;
        logic       free_hit;
        logic       lpm_hit;
        logic       lpm_direct;
        logic       same_hop;
        logic       reach;
        logic       metric_eq;
        logic       metric_less;
        logic [1:0] op;
    } t_stat;

    function automatic logic [31:0] len_mask(input logic [5:0] len);
        logic [31:0] m;
        m = '0;
        if (len != 6'd0) begin
            m = 32'hffffffff << (6'd32 - len);
        end
        return m;
    endfunction
endpackage

/* hw/rtl/rrt_ram.sv */
// generic single port ram with registered read
module rrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* hw/rtl/rrt_datapath.sv */
// route table storage, scan engine and result register
module rrt_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rrt_pkg::t_cmd i_cmd,
    output rrt_pkg::t_stat o_stat,
    input  logic [1:0]    i_op,
    input  logic [31:0]   i_addr,
    input  logic [5:0]    i_len,
    input  logic [31:0]   i_nh,
    input  logic [3:0]    i_port,
    input  logic [7:0]    i_metric,
    input  logic [31:0]   i_sender,
    input  logic [7:0]    i_inf,
    output logic [3:0]    o_outcome,
    output logic [31:0]   o_nh,
    output logic [3:0]    o_port,
    output logic [7:0]    o_metric,
    output logic          o_direct
);
    import rrt_pkg::*;

    logic [1:0]  r_op;
    logic [31:0] r_prefix, r_hop, r_nh_in, r_lpm_addr;
    logic [5:0]  r_len;
    logic [3:0]  r_port_in;
    logic [8:0]  r_m;
    logic [7:0]  r_met_in;

    logic             r_valid [TABLE_DEPTH];
    logic [CNT_W-1:0] r_cnt;
    logic             r_scan, r_lpm_mode, r_rd_ok, r_rd_valid, r_done;
    logic [IDX_W-1:0] r_rd_idx, r_exact_idx, r_free_idx;
    logic             r_exact_hit, r_free_hit, r_lpm_hit;
    logic [5:0]       r_best_len;
    logic [ROUTE_W-1:0] r_exact_route, r_lpm_route;

    logic               we_key, we_route;
    logic [IDX_W-1:0]   ram_addr;
    logic [KEY_W-1:0]   key_rd;
    logic [ROUTE_W-1:0] route_rd, route_wd, new_route, res_route;
    logic [5:0]         e_len, in_len;
    logic [31:0]        e_pre;

    always_comb begin
        case (i_cmd.route_sel)
            RSEL_INSERT:  new_route = {r_nh_in, r_port_in, r_met_in};
            RSEL_RIP_ADD: new_route = {r_hop, r_lpm_route[11:8], r_m[7:0]};
            RSEL_UPDATE:  new_route = {r_hop, r_exact_route[11:8], r_m[7:0]};
            RSEL_REROUTE: new_route = {r_hop, r_lpm_route[11:8], r_m[7:0]};
            default:      new_route = {r_hop, r_lpm_route[11:8], r_m[7:0]};
        endcase
    end

    always_comb begin
        case (i_cmd.res_src)
            SRC_NEW:   res_route = new_route;
            SRC_EXACT: res_route = r_exact_route;
            SRC_LPM:   res_route = r_lpm_route;
            default:   res_route = '0;
        endcase
    end

    assign in_len = (i_len > 6'd32) ? 6'd32 : i_len;

    assign we_key   = i_cmd.wr_new;
    assign we_route = i_cmd.wr_new | i_cmd.wr_route;
    assign route_wd = new_route;
    always_comb begin
        if (i_cmd.wr_new) begin
            ram_addr = r_free_idx;
        end else if (i_cmd.wr_route) begin
            ram_addr = r_exact_idx;
        end else begin
            ram_addr = r_cnt[IDX_W-1:0];
        end
    end

    rrt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key (
        .i_clk(i_clk), .i_we(we_key), .i_addr(ram_addr),
        .i_wdata({r_prefix, r_len}), .o_rdata(key_rd)
    );
    rrt_ram #(.WIDTH(ROUTE_W), .DEPTH(TABLE_DEPTH)) u_route (
        .i_clk(i_clk), .i_we(we_route), .i_addr(ram_addr),
        .i_wdata(route_wd), .o_rdata(route_rd)
    );

    assign e_len = key_rd[5:0];
    assign e_pre = key_rd[37:6];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_len     <= in_len;
            r_prefix  <= i_addr & len_mask(in_len);
            r_hop     <= (i_nh != 32'd0) ? i_nh : i_sender;
            r_nh_in   <= i_nh;
            r_port_in <= i_port;
            r_met_in  <= i_metric;
            r_m       <= {1'b0, i_metric} + 9'd1;
            r_lpm_addr <= (i_op == OP_LOOKUP) ? i_addr :
                          ((i_nh != 32'd0) ? i_nh : i_sender);
        end
        if (i_cmd.res_load) begin
            o_outcome <= i_cmd.res_oc;
            o_nh      <= res_route[43:12];
            o_port    <= res_route[11:8];
            o_metric  <= res_route[7:0];
            o_direct  <= (i_cmd.res_src != SRC_NONE) && (res_route[43:12] == 32'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) r_valid[i] <= 1'b0;
            r_scan <= 1'b0;
            r_rd_ok <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.wr_new) r_valid[r_free_idx] <= 1'b1;
            if (i_cmd.del) r_valid[r_exact_idx] <= 1'b0;
            if (i_cmd.scan_start) begin
                r_scan <= 1'b1;
                r_cnt <= '0;
                r_rd_ok <= 1'b0;
                r_lpm_mode <= i_cmd.scan_lpm;
                r_best_len <= '0;
                r_lpm_hit <= 1'b0;
                if (!i_cmd.scan_lpm) begin
                    r_exact_hit <= 1'b0;
                    r_free_hit <= 1'b0;
                end
            end else if (r_scan || r_rd_ok) begin
                r_rd_ok <= r_scan;
                r_rd_idx <= r_cnt[IDX_W-1:0];
                r_rd_valid <= r_valid[r_cnt[IDX_W-1:0]];
                if (r_scan) begin
                    if (r_cnt == CNT_W'(TABLE_DEPTH - 1)) r_scan <= 1'b0;
                    r_cnt <= r_cnt + CNT_W'(1);
                end else begin
                    r_done <= 1'b1;
                end
                if (r_rd_ok) begin
                    if (!r_lpm_mode) begin
                        if (r_rd_valid && key_rd == {r_prefix, r_len}
                            && !r_exact_hit) begin
                            r_exact_hit <= 1'b1;
                            r_exact_idx <= r_rd_idx;
                            r_exact_route <= route_rd;
                        end
                        if (!r_rd_valid && !r_free_hit) begin
                            r_free_hit <= 1'b1;
                            r_free_idx <= r_rd_idx;
                        end
                    end else if (r_rd_valid && e_len != 6'd0 && e_len <= 6'd32
                                 && e_len > r_best_len
                                 && (r_lpm_addr & len_mask(e_len)) == e_pre) begin
                        r_lpm_hit <= 1'b1;
                        r_best_len <= e_len;
                        r_lpm_route <= route_rd;
                    end
                end
            end
        end
    end

    assign o_stat.scan_done   = r_done;
    assign o_stat.exact_hit   = r_exact_hit;
    assign o_stat.free_hit    = r_free_hit;
    assign o_stat.lpm_hit     = r_lpm_hit;
    assign o_stat.lpm_direct  = r_lpm_route[43:12] == 32'd0;
    assign o_stat.same_hop    = r_exact_route[43:12] == r_hop;
    assign o_stat.reach       = r_m < {1'b0, i_inf};
    assign o_stat.metric_eq   = r_m == {1'b0, r_exact_route[7:0]};
    assign o_stat.metric_less = r_m < {1'b0, r_exact_route[7:0]};
    assign o_stat.op          = r_op;
endmodule

/* hw/rtl/rrt_ctrl.sv */
// operation sequencer for the route table
module rrt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rrt_pkg::t_cmd  o_cmd,
    input  rrt_pkg::t_stat i_stat
);
    import rrt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN1, ST_DECIDE, ST_SCAN2, ST_FINISH
    } t_state;

    t_state r_state;
    logic   in_acc;

    assign o_in_ready  = (r_state == ST_IDLE) && (!o_out_valid || i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load = in_acc;
            end
            ST_SCAN1: ;
            ST_DECIDE: begin
                o_cmd.res_load = 1'b1;
                unique case (i_stat.op)
                    OP_INSERT: begin
                        o_cmd.route_sel = RSEL_INSERT;
                        o_cmd.res_src = SRC_NEW;
                        if (i_stat.exact_hit) begin
                            o_cmd.wr_route = 1'b1;
                            o_cmd.res_oc = OC_REPLACED;
                        end else if (i_stat.free_hit) begin
                            o_cmd.wr_new = 1'b1;
                            o_cmd.res_oc = OC_ADDED;
                        end else begin
                            o_cmd.res_oc = OC_FULL;
                            o_cmd.res_src = SRC_NONE;
                        end
                    end
                    OP_DELETE: begin
                        if (i_stat.exact_hit) begin
                            o_cmd.del = 1'b1;
                            o_cmd.res_oc = OC_DELETED;
                            o_cmd.res_src = SRC_EXACT;
                        end else begin
                            o_cmd.res_oc = OC_MISS;
                        end
                    end
                    OP_LOOKUP: begin
                        o_cmd.res_load = 1'b0;
                    end
                    OP_RIP: begin
                        if (!i_stat.exact_hit) begin
                            if (!i_stat.reach) begin
                                o_cmd.res_oc = OC_UNCHANGED;
                            end else begin
                                o_cmd.res_load = 1'b0;
                            end
                        end else if (i_stat.same_hop) begin
                            o_cmd.res_src = SRC_EXACT;
                            if (!i_stat.reach) begin
                                o_cmd.del = 1'b1;
                                o_cmd.res_oc = OC_DELETED;
                            end else if (!i_stat.metric_eq) begin
                                o_cmd.route_sel = RSEL_UPDATE;
                                o_cmd.wr_route = 1'b1;
                                o_cmd.res_src = SRC_NEW;
                                o_cmd.res_oc = OC_UPDATED;
                            end else begin
                                o_cmd.res_oc = OC_UNCHANGED;
                            end
                        end else if (!i_stat.reach || !i_stat.metric_less) begin
                            o_cmd.res_src = SRC_EXACT;
                            o_cmd.res_oc = OC_UNCHANGED;
                        end else begin
                            o_cmd.res_load = 1'b0;
                        end
                    end
                    default: ;
                endcase
                o_cmd.scan_start = !o_cmd.res_load;
                o_cmd.scan_lpm = 1'b1;
            end
            ST_SCAN2: ;
            ST_FINISH: begin
                o_cmd.res_load = 1'b1;
                if (i_stat.op == OP_LOOKUP) begin
                    o_cmd.res_oc = i_stat.lpm_hit ? OC_HIT : OC_MISS;
                    o_cmd.res_src = i_stat.lpm_hit ? SRC_LPM : SRC_NONE;
                end else if (!i_stat.lpm_hit) begin
                    o_cmd.res_oc = OC_UNKNOWN;
                end else if (!i_stat.exact_hit) begin
                    if (i_stat.free_hit) begin
                        o_cmd.route_sel = RSEL_RIP_ADD;
                        o_cmd.wr_new = 1'b1;
                        o_cmd.res_src = SRC_NEW;
                        o_cmd.res_oc = OC_ADDED;
                    end else begin
                        o_cmd.res_oc = OC_FULL;
                    end
                end else if (i_stat.lpm_direct) begin
                    o_cmd.res_src = SRC_EXACT;
                    o_cmd.res_oc = OC_UNCHANGED;
                end else begin
                    o_cmd.route_sel = RSEL_REROUTE;
                    o_cmd.wr_route = 1'b1;
                    o_cmd.res_src = SRC_NEW;
                    o_cmd.res_oc = OC_REROUTED;
                end
            end
            default: ;
        endcase
        if (r_state == ST_IDLE && in_acc) begin
            o_cmd.scan_start = 1'b1;
            o_cmd.scan_lpm = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE:   if (in_acc) r_state <= ST_SCAN1;
                ST_SCAN1:  if (i_stat.scan_done) r_state <= ST_DECIDE;
                ST_DECIDE: begin
                    if (o_cmd.res_load) begin
                        r_state <= ST_IDLE;
                        o_out_valid <= 1'b1;
                    end else begin
                        r_state <= ST_SCAN2;
                    end
                end
                ST_SCAN2:  if (i_stat.scan_done) r_state <= ST_FINISH;
                ST_FINISH: begin
                    r_state <= ST_IDLE;
                    o_out_valid <= 1'b1;
                end
                default:   r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

/* hw/rtl/rip_route_table_lpm_top.sv */
// top level of the route table with longest prefix match and rip update
//  channel  | direction | fields
//  s_axis   | in        | tdata: operation, addr, pfx_len, hop_addr, port, metric, sender
//  m_axis   | out       | tdata: outcome, found_hop, found_port, found_metric, is_direct
//  cfg      | in        | infinite_metric
// insert and delete: the result follows one sweep of the rams after the word is taken
// lookup and a rip update that needs the hop: exact sweep then longest match sweep
// a rip update decided by the exact sweep alone: one sweep
// the ram read port sets the pace, one slot per cycle
// reset empties the table at once; a word is taken no earlier than the edge the result leaves
module rip_route_table_lpm_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,  // operation, addr, pfx_len, hop_addr, port, metric, sender
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [55:0]  m_axis_tdata,  // outcome, found_hop, found_port, found_metric, is_direct
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_data
);
    import rrt_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic [7:0] r_inf;
    logic [3:0] oc;
    logic [31:0] fnh;
    logic [3:0] fport;
    logic [7:0] fmet;
    logic fdir;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inf <= 8'd16;
        end else if (i_cfg_valid) begin
            r_inf <= i_cfg_data;
        end
    end

    rrt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(cmd), .i_stat(stat)
    );

    rrt_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_op(s_axis_tdata[1:0]), .i_addr(s_axis_tdata[33:2]),
        .i_len(s_axis_tdata[39:34]), .i_nh(s_axis_tdata[71:40]),
        .i_port(s_axis_tdata[75:72]), .i_metric(s_axis_tdata[83:76]),
        .i_sender(s_axis_tdata[115:84]), .i_inf(r_inf),
        .o_outcome(oc), .o_nh(fnh), .o_port(fport), .o_metric(fmet), .o_direct(fdir)
    );

    assign m_axis_tdata = {7'd0, fdir, fmet, fport, fnh, oc};
endmodule

/* hw/rtl/rrt_checker.sv */
// port level checks for the route table
module rrt_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [55:0]  m_axis_tdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_no_accept_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken during work");
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 !$rose(m_axis_tvalid))
        else $error("result too early");
    a_outcome_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd9)
        else $error("bad outcome code");
endmodule

bind rip_route_table_lpm_top rrt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
